// File: design/udp_checksum_pseudo_header_defines.svh
// Assertion macros for the checksum block's checker.
`ifndef UDP_CHECKSUM_PSEUDO_HEADER_DEFINES_SVH
`define UDP_CHECKSUM_PSEUDO_HEADER_DEFINES_SVH

// Concurrent check, held off while reset is high.
`define UDPCS_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Concurrent check that also runs through reset.
`define UDPCS_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: design/udpcs_pkg.sv
// Types, constants and ones' complement helpers for the UDP checksum block.
package udpcs_pkg;

   localparam logic [15:0] PROTO_UDP      = 16'h0011;
   localparam logic [15:0] LEN_SAT        = 16'hFFFF;
   localparam logic [16:0] COUNT_CAP      = 17'h10000;
   localparam logic [5:0]  POS_MAX        = 6'd63;
   localparam logic [5:0]  V4_ADDR_FIRST  = 6'd12;
   localparam logic [5:0]  V4_ADDR_LAST   = 6'd19;
   localparam logic [5:0]  V6_ADDR_FIRST  = 6'd8;
   localparam logic [5:0]  V6_ADDR_LAST   = 6'd39;
   localparam logic [16:0] CKSUM_FIELD_HI = 17'd6;
   localparam logic [16:0] CKSUM_FIELD_LO = 17'd7;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       section;
      logic       ip_version;
      logic       last;
   } req_item_type;

   typedef struct packed {
      logic [15:0] udp_checksum;
      logic [15:0] udp_length;
      logic        length_error;
   } rsp_item_type;

   // ones' complement add with end-around carry
   function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[15:0] + {15'b0, s[16]};
   endfunction

   // fold an 18-bit plain sum of up to four words into ones' complement form
   function automatic logic [15:0] oc_fold(input logic [17:0] s);
      logic [16:0] t;
      t = {1'b0, s[15:0]} + {15'b0, s[17:16]};
      return t[15:0] + {15'b0, t[16]};
   endfunction

endpackage

// File: design/udpcs_in_reg.sv
// Input register stage: holds one byte transaction and drives the request stall.
module udpcs_in_reg (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  udpcs_pkg::req_item_type  req_item,
   output logic                     req_stall,
   input  logic                     advance,
   output logic                     item_valid,
   output udpcs_pkg::req_item_type  item
);

   logic                    valid_ff;
   logic                    valid_in;
   udpcs_pkg::req_item_type item_ff;
   logic                    take;

   assign req_stall  = valid_ff && !advance;
   assign take       = req_valid && !req_stall;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_comb begin
      if (!valid_ff || advance) begin
         valid_in = req_valid;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= req_item;
      end
   end

endmodule

// File: design/udpcs_core.sv
// Checksum state update and result register.
module udpcs_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     item_valid,
   input  udpcs_pkg::req_item_type  item,
   input  logic                     advance,
   output logic                     item_ready,
   output logic                     rsp_valid,
   output udpcs_pkg::rsp_item_type  rsp_item
);

   logic [15:0] sum_ff,     sum_in;
   logic [5:0]  pos_ff,     pos_in;
   logic [16:0] count_ff,   count_in;
   logic [7:0]  pending_ff, pending_in;
   logic        odd_ff,     odd_in;
   logic        rsp_valid_ff, rsp_valid_in;
   udpcs_pkg::rsp_item_type rsp_ff, rsp_in;

   logic        step;
   logic        is_addr;
   logic [15:0] ip_word;
   logic [7:0]  udp_byte;
   logic [16:0] count_next;
   logic [15:0] last_word;
   logic        len_err;
   logic [15:0] len;
   logic [17:0] total;
   logic [15:0] folded;
   logic [15:0] cksum;
   logic        emit;

   // only the closing UDP byte needs the result register; other bytes go on
   assign item_ready = advance || !(item.section && item.last);
   assign step = item_valid && item_ready;
   assign emit = step && item.section && item.last;

   always_comb begin
      if (item.ip_version) begin
         is_addr = (pos_ff >= udpcs_pkg::V6_ADDR_FIRST) && (pos_ff <= udpcs_pkg::V6_ADDR_LAST);
      end else begin
         is_addr = (pos_ff >= udpcs_pkg::V4_ADDR_FIRST) && (pos_ff <= udpcs_pkg::V4_ADDR_LAST);
      end
      ip_word = pos_ff[0] ? {8'h00, item.data_byte} : {item.data_byte, 8'h00};

      // checksum field itself counts as zero
      if (count_ff == udpcs_pkg::CKSUM_FIELD_HI || count_ff == udpcs_pkg::CKSUM_FIELD_LO) begin
         udp_byte = 8'h00;
      end else begin
         udp_byte = item.data_byte;
      end
      count_next = (count_ff == udpcs_pkg::COUNT_CAP) ? count_ff : count_ff + 17'd1;

      // pair word, or the trailing odd byte padded with a zero low byte
      last_word = odd_ff ? {pending_ff, udp_byte} : {udp_byte, 8'h00};
      len_err   = count_next[16];
      len       = len_err ? udpcs_pkg::LEN_SAT : count_next[15:0];
      total     = {2'b00, sum_ff} + {2'b00, last_word} + {2'b00, udpcs_pkg::PROTO_UDP}
                  + {2'b00, len};
      folded    = udpcs_pkg::oc_fold(total);
      cksum     = ~folded;
      if (cksum == 16'h0000) begin
         cksum = 16'hFFFF;
      end
   end

   always_comb begin
      sum_in     = sum_ff;
      pos_in     = pos_ff;
      count_in   = count_ff;
      pending_in = pending_ff;
      odd_in     = odd_ff;
      if (step) begin
         if (!item.section) begin
            if (is_addr) begin
               sum_in = udpcs_pkg::oc_add(sum_ff, ip_word);
            end
            if (pos_ff != udpcs_pkg::POS_MAX) begin
               pos_in = pos_ff + 6'd1;
            end
         end else if (item.last) begin
            sum_in     = 16'h0000;
            pos_in     = 6'd0;
            count_in   = 17'd0;
            pending_in = 8'h00;
            odd_in     = 1'b0;
         end else begin
            count_in = count_next;
            if (odd_ff) begin
               sum_in     = udpcs_pkg::oc_add(sum_ff, {pending_ff, udp_byte});
               pending_in = 8'h00;
               odd_in     = 1'b0;
            end else begin
               pending_in = udp_byte;
               odd_in     = 1'b1;
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = emit;
      end
      rsp_in.udp_checksum = cksum;
      rsp_in.udp_length   = len;
      rsp_in.length_error = len_err;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= 16'h0000;
         pos_ff       <= 6'd0;
         count_ff     <= 17'd0;
         pending_ff   <= 8'h00;
         odd_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sum_ff       <= sum_in;
         pos_ff       <= pos_in;
         count_ff     <= count_in;
         pending_ff   <= pending_in;
         odd_ff       <= odd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

// File: design/udp_checksum_pseudo_header.sv
// Top level of the streaming UDP checksum engine with IPv4/IPv6 pseudo-header.
//
// Input channel (req_*): one byte per transaction. The IP header comes first
// (req_section = 0, 20 bytes for IPv4 or 40 for IPv6 per req_ip_version),
// then the UDP header and payload (req_section = 1). req_last on a UDP byte
// closes the packet; on an IP header byte it is ignored.
// Result channel (rsp_*): one transaction per packet with the checksum
// (high byte goes to UDP byte 6, zero sent as 0xFFFF), the counted UDP
// length (saturating at 65535) and length_error for oversized segments.
// The closing UDP byte passes the input register, where a held result can
// stall it, then loads the result register and raises rsp_valid.
// Throughput: one byte per cycle unless a held result stalls a closing byte;
// each byte passes an input register, then at most one ones' complement add
// into the running sum, or on the last byte a four-word sum and fold.
// A held result only blocks a closing UDP byte: other bytes keep flowing
// into the running sum; the next closing byte waits in the input register
// with req_stall high until rsp_stall drops.
// Synchronous reset clears the sum, counters and both valid flags.
module udp_checksum_pseudo_header (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_section,
   input  logic        req_ip_version,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_udp_checksum,
   output logic [15:0] rsp_udp_length,
   output logic        rsp_length_error
);

   udpcs_pkg::req_item_type req_item;
   udpcs_pkg::req_item_type item;
   udpcs_pkg::rsp_item_type rsp_item;
   logic                    item_valid;
   logic                    item_ready;
   logic                    advance;

   assign req_item.data_byte  = req_data_byte;
   assign req_item.section    = req_section;
   assign req_item.ip_version = req_ip_version;
   assign req_item.last       = req_last;

   // pipeline moves whenever the result register is free or being taken
   assign advance = !rsp_valid || !rsp_stall;

   udpcs_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_item   (req_item),
      .req_stall  (req_stall),
      .advance    (item_ready),
      .item_valid (item_valid),
      .item       (item)
   );

   udpcs_core u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .advance    (advance),
      .item_ready (item_ready),
      .rsp_valid  (rsp_valid),
      .rsp_item   (rsp_item)
   );

   assign rsp_udp_checksum = rsp_item.udp_checksum;
   assign rsp_udp_length   = rsp_item.udp_length;
   assign rsp_length_error = rsp_item.length_error;

endmodule

// File: design/udpcs_checker.sv
// Port-level checker for the UDP checksum block, bound to the top level.
`include "udp_checksum_pseudo_header_defines.svh"

module udpcs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_section,
   input logic        req_last,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_udp_checksum,
   input logic [15:0] rsp_udp_length,
   input logic        rsp_length_error
);

   `UDPCS_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid, "result dropped while stalled")
   `UDPCS_ASSERT(a_cksum_nonzero, rsp_valid |-> rsp_udp_checksum != 16'h0000, "zero checksum sent")
   `UDPCS_ASSERT(a_err_len, rsp_valid && rsp_length_error |-> rsp_udp_length == 16'hFFFF, "length error without saturated length")
   `UDPCS_ASSERT(a_rsp_cause, $rose(rsp_valid) |-> $past(req_valid && !req_stall && req_section && req_last, 2), "result without a last UDP byte")
   `UDPCS_ASSERT_ALWAYS(a_reset_clear, $past(reset) |-> !rsp_valid, "result valid after reset")

endmodule

bind udp_checksum_pseudo_header udpcs_checker u_udpcs_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_section      (req_section),
   .req_last         (req_last),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_udp_checksum (rsp_udp_checksum),
   .rsp_udp_length   (rsp_udp_length),
   .rsp_length_error (rsp_length_error)
);
